// ===== rtl/assert_macros.svh =====
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

// ===== rtl/ppic_pkg.sv =====
`timescale 1ns / 1ps
package ppic_pkg;
    localparam int unsigned DEF_MAX_POINTS = 65535;
    localparam int unsigned DEF_FRAC_BITS  = 16;
    localparam int unsigned CNT_W   = 17;
    localparam int unsigned ACC_W   = 72;
    localparam int unsigned NSQ_W   = 66;
    localparam int unsigned ROOT_W  = 33;

    typedef enum logic [2:0] {
        REG_COEF_A    = 3'd0,
        REG_COEF_B    = 3'd1,
        REG_COEF_C    = 3'd2,
        REG_COEF_D    = 3'd3,
        REG_THRESHOLD = 3'd4,
        REG_OUT_START = 3'd5
    } reg_idx_t;

    // handoff from the arithmetic core to the top level
    typedef struct packed {
        logic        done;
        logic        busy;
    } core_status_t;
endpackage

// ===== rtl/ppic_core.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ppic_core
    import ppic_pkg::*;
#(
    parameter int unsigned FRAC_BITS = DEF_FRAC_BITS
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic signed [31:0]  coef_a,
    input  logic signed [31:0]  coef_b,
    input  logic signed [31:0]  coef_c,
    input  logic signed [31:0]  coef_d,
    input  logic signed [31:0]  px,
    input  logic signed [31:0]  py,
    input  logic signed [31:0]  pz,
    output core_status_t        status,
    output logic signed [31:0]  res_out,
    output logic        [30:0]  dist_out,
    output logic                nz_out
);
    localparam int unsigned QW = 32 + FRAC_BITS;

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_SAT, S_SQRT, S_DIV, S_DONE
    } state_t;

    state_t                    state_reg;
    logic [1:0]                term_reg;
    logic [5:0]                bit_reg;
    logic [ACC_W-1:0]          acc_reg;   // residual accumulator
    logic [ACC_W-1:0]          nsq_reg;   // sum of squares, then sqrt remainder
    logic [63:0]               mcand_reg; // shifted multiplicand, sign extended
    logic [31:0]               mplier_reg;
    logic                      sq_reg;    // pass squares the coefficient
    logic [ROOT_W-1:0]         root_reg;
    logic [NSQ_W-1:0]          rad_reg;
    logic [QW-1:0]             quo_reg;
    logic [ROOT_W:0]           rem_reg;
    logic signed [31:0]        res_reg;
    logic [30:0]               dist_reg;
    logic                      nz_reg;
    logic                      done_reg;

    logic signed [31:0]        op_a;
    logic [ROOT_W+1:0]         trial;
    logic [ROOT_W+1:0]         dtrial;
    logic [ROOT_W+1:0]         rnext;
    logic [ACC_W-1:0]          sum_sh;
    logic [31:0]               absr;

    // operand of the current product pass
    always_comb
    begin
        case (term_reg)
            2'd0: op_a = coef_a;
            2'd1: op_a = coef_b;
            default: op_a = coef_c;
        endcase
    end

    assign sum_sh = $signed(acc_reg) >>> FRAC_BITS;
    assign absr   = res_reg[31] ? (~res_reg + 32'd1) : res_reg;
    // sqrt step: two radicand bits in, one root bit out
    assign rnext  = {nsq_reg[ROOT_W-1:0], rad_reg[NSQ_W-1 -: 2]};
    assign trial  = {root_reg[ROOT_W-1:0], 2'b01};
    // divide step: restoring, one quotient bit
    assign dtrial = {rem_reg, quo_reg[QW-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            term_reg  <= '0;
            bit_reg   <= '0;
            sq_reg    <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        state_reg  <= S_MUL;
                        term_reg   <= '0;
                        bit_reg    <= '0;
                        sq_reg     <= 1'b0;
                        acc_reg    <= ACC_W'($signed(coef_d)) << FRAC_BITS;
                        nsq_reg    <= '0;
                        mcand_reg  <= 64'($signed(coef_a));
                        mplier_reg <= px;
                        nz_reg     <= (coef_a == 0) && (coef_b == 0) && (coef_c == 0);
                    end
                end
                S_MUL:
                begin
                    // one multiplier bit per cycle, top bit has negative weight
                    if (mplier_reg[bit_reg[4:0]])
                    begin
                        if (bit_reg == 6'd31)
                        begin
                            if (sq_reg) nsq_reg <= nsq_reg - ACC_W'($signed(mcand_reg));
                            else        acc_reg <= acc_reg - ACC_W'($signed(mcand_reg));
                        end
                        else
                        begin
                            if (sq_reg) nsq_reg <= nsq_reg + ACC_W'($signed(mcand_reg));
                            else        acc_reg <= acc_reg + ACC_W'($signed(mcand_reg));
                        end
                    end
                    if (bit_reg == 6'd31)
                    begin
                        bit_reg <= '0;
                        if (term_reg == 2'd2 && sq_reg)
                        begin
                            state_reg <= S_SAT;
                        end
                        else
                        begin
                            if (sq_reg) term_reg <= term_reg + 2'd1;
                            sq_reg     <= ~sq_reg;
                            mcand_reg  <= 64'($signed(sq_reg ? (term_reg == 2'd0 ? coef_b
                                            : coef_c) : op_a));
                            mplier_reg <= sq_reg ? (term_reg == 2'd0 ? py : pz) : op_a;
                        end
                    end
                    else
                    begin
                        bit_reg   <= bit_reg + 6'd1;
                        mcand_reg <= mcand_reg << 1;
                    end
                end
                S_SAT:
                begin
                    if ($signed(sum_sh) > $signed(ACC_W'(32'sh7fffffff)))
                        res_reg <= 32'sh7fffffff;
                    else if ($signed(sum_sh) < $signed({{(ACC_W-32){1'b1}}, 32'h80000000}))
                        res_reg <= 32'sh80000000;
                    else
                        res_reg <= sum_sh[31:0];
                    rad_reg   <= nsq_reg[NSQ_W-1:0];
                    nsq_reg   <= '0;
                    root_reg  <= '0;
                    bit_reg   <= '0;
                    state_reg <= S_SQRT;
                end
                S_SQRT:
                begin
                    rad_reg <= rad_reg << 2;
                    if (rnext >= trial)
                    begin
                        nsq_reg  <= ACC_W'(rnext - trial);
                        root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
                    end
                    else
                    begin
                        nsq_reg  <= ACC_W'(rnext);
                        root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
                    end
                    if (bit_reg == 6'(ROOT_W - 1))
                    begin
                        bit_reg   <= '0;
                        quo_reg   <= QW'(absr) << FRAC_BITS;
                        rem_reg   <= '0;
                        state_reg <= S_DIV;
                    end
                    else
                    begin
                        bit_reg <= bit_reg + 6'd1;
                    end
                end
                S_DIV:
                begin
                    if (dtrial >= {1'b0, root_reg})
                    begin
                        rem_reg <= (ROOT_W+1)'(dtrial - {1'b0, root_reg});
                        quo_reg <= {quo_reg[QW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= dtrial[ROOT_W:0];
                        quo_reg <= {quo_reg[QW-2:0], 1'b0};
                    end
                    if (bit_reg == 6'(QW - 1))
                        state_reg <= S_DONE;
                    else
                        bit_reg <= bit_reg + 6'd1;
                end
                S_DONE:
                begin
                    if (nz_reg || root_reg == '0)
                        dist_reg <= '0;
                    else if (quo_reg > QW'(31'h7fffffff))
                        dist_reg <= 31'h7fffffff;
                    else
                        dist_reg <= quo_reg[30:0];
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) done_reg <= 1'b0;
        else        done_reg <= (state_reg == S_DONE);
    end
    assign status   = '{done: done_reg, busy: (state_reg != S_IDLE)};
    assign res_out  = res_reg;
    assign dist_out = dist_reg;
    assign nz_out   = nz_reg;

    `ASSERT_NEVER(a_start_busy, clk, rst_n, start && state_reg != S_IDLE, "start while busy")
    `ASSERT_IMPL(a_done_after, clk, rst_n, status.done |-> $past(state_reg == S_DONE), "stray done")
    `ASSERT_IMPL(a_div_bits, clk, rst_n, state_reg == S_DIV |-> bit_reg < 6'(QW), "div overrun")
endmodule

// ===== rtl/plane_point_inlier_classifier_top.sv =====
`timescale 1ns / 1ps
// steps: capture, multiply, saturate, sqrt, divide, output register; Q16.16 at FRAC_BITS = 16
// throughput: one item at a time, set by the bit-serial multiply and root/divide loops
// the next item enters only after the previous result has left the output register
// reset: asynchronous active low; coefficients clear, d to -1.0, counters to zero
`include "assert_macros.svh"
module plane_point_inlier_classifier_top
    import ppic_pkg::*;
#(
    parameter int unsigned MAX_POINTS = DEF_MAX_POINTS,
    parameter int unsigned FRAC_BITS  = DEF_FRAC_BITS
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] px,
    input  logic signed [31:0] py,
    input  logic signed [31:0] pz,
    input  logic               set_end,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] residual,
    output logic [30:0]        distance,
    output logic               norm_zero,
    output logic               is_inlier,
    output logic [16:0]        slot_index,
    output logic               set_done
);
    // counter cap is min(MAX_POINTS, 2^17-1)
    localparam logic [CNT_W-1:0] CAP = (MAX_POINTS < 131071) ? CNT_W'(MAX_POINTS)
                                                             : {CNT_W{1'b1}};

    logic signed [31:0] coef_a_reg, coef_b_reg, coef_c_reg, coef_d_reg;
    logic [30:0]        thr_reg;
    logic [15:0]        out_start_reg;
    logic [CNT_W-1:0]   in_cnt_reg, out_cnt_reg;
    logic signed [31:0] px_reg, py_reg, pz_reg;
    logic               last_reg;
    logic               busy_reg;   // item inside the core
    logic               start_reg;
    core_status_t       cst;
    logic signed [31:0] c_res;
    logic [30:0]        c_dist;
    logic               c_nz;
    logic [31:0]        absr;
    logic               inl;
    logic               in_acc, out_acc;

    assign in_stall = busy_reg || out_valid;
    assign in_acc   = in_valid && !in_stall;
    assign out_acc  = out_valid && !out_stall;

    // config writes, unknown indexes ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_a_reg    <= '0;
            coef_b_reg    <= '0;
            coef_c_reg    <= '0;
            coef_d_reg    <= -(32'sd1 <<< FRAC_BITS);
            thr_reg       <= '0;
            out_start_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_COEF_A:    coef_a_reg    <= cfg_data;
                REG_COEF_B:    coef_b_reg    <= cfg_data;
                REG_COEF_C:    coef_c_reg    <= cfg_data;
                REG_COEF_D:    coef_d_reg    <= cfg_data;
                REG_THRESHOLD: thr_reg       <= cfg_data[30:0];
                REG_OUT_START: out_start_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // capture the item and kick the core in the next cycle
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            px_reg   <= px;
            py_reg   <= py;
            pz_reg   <= pz;
            last_reg <= set_end;
        end
    end

    ppic_core #(.FRAC_BITS(FRAC_BITS)) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start_reg),
        .coef_a   (coef_a_reg),
        .coef_b   (coef_b_reg),
        .coef_c   (coef_c_reg),
        .coef_d   (coef_d_reg),
        .px       (px_reg),
        .py       (py_reg),
        .pz       (pz_reg),
        .status   (cst),
        .res_out  (c_res),
        .dist_out (c_dist),
        .nz_out   (c_nz)
    );

    assign absr = c_res[31] ? (~c_res + 32'd1) : c_res;
    assign inl  = absr < {1'b0, thr_reg};

    // item stays busy until its result lands in the output register;
    // a pending result blocks the next item's entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            start_reg   <= 1'b0;
            out_valid   <= 1'b0;
            in_cnt_reg  <= '0;
            out_cnt_reg <= '0;
        end
        else
        begin
            start_reg <= in_acc;
            if (cst.done)
            begin
                // output register is free: no result pending while an item runs
                busy_reg   <= 1'b0;
                out_valid  <= 1'b1;
                residual   <= c_res;
                distance   <= c_dist;
                norm_zero  <= c_nz;
                is_inlier  <= inl;
                set_done   <= last_reg;
                if (inl)
                    slot_index <= in_cnt_reg;
                else
                    slot_index <= CNT_W'({1'b0, out_start_reg}) + out_cnt_reg;
                if (last_reg)
                begin
                    in_cnt_reg  <= '0;
                    out_cnt_reg <= '0;
                end
                else if (inl)
                begin
                    if (in_cnt_reg < CAP) in_cnt_reg <= in_cnt_reg + 1'b1;
                end
                else
                begin
                    if (out_cnt_reg < CAP) out_cnt_reg <= out_cnt_reg + 1'b1;
                end
            end
            else
            begin
                if (in_acc) busy_reg <= 1'b1;
                if (out_acc) out_valid <= 1'b0;
            end
        end
    end

    `ASSERT_NEVER(a_no_overwrite, clk, rst_n, cst.done && out_valid && out_stall, "result lost")
    `ASSERT_IMPL(a_start_follows, clk, rst_n, in_acc |=> start_reg, "core not started")
    `ASSERT_NEVER(a_cnt_cap, clk, rst_n, in_cnt_reg > CAP || out_cnt_reg > CAP, "count past cap")
endmodule
